FILE: src/pfqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfqs_pkg
// Shared types and constants of the per-flow QoS statistics table.
// ----------------------------------------------------------------------------
package pfqs_pkg;

	localparam int UE_W    = 16;
	localparam int QFI_W   = 6;
	localparam int LEN_W   = 16;
	localparam int CNT_W   = 64;
	localparam int KEY_W   = UE_W + QFI_W;

	localparam int IN_DATA_W  = 40;  // ue, qfi, length = 38 bits, padded to bytes
	localparam int OUT_DATA_W = 152; // ue, qfi, packets, bytes = 150 bits, padded
	localparam int OUT_USER_W = 2;   // new_flow, stored

	localparam int FIRST_PERIOD  = 100;
	localparam int SECOND_PERIOD = 1000;
	localparam int RES1_W = $clog2(FIRST_PERIOD);
	localparam int RES2_W = $clog2(SECOND_PERIOD);

	localparam int REG_IDX_W  = 1;
	localparam int REG_DATA_W = QFI_W;
	localparam logic [REG_IDX_W-1:0] REG_WATCH_FIRST  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_WATCH_SECOND = 1'b1;
	localparam logic [QFI_W-1:0] WATCH_FIRST_RST  = 6'd5;
	localparam logic [QFI_W-1:0] WATCH_SECOND_RST = 6'd9;

	// One table slot as held in memory. The residues track packets modulo the
	// two report periods so that no wide modulo is needed on the counter.
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  packets;
		logic [CNT_W-1:0]  bytes;
		logic [RES1_W-1:0] res_first;
		logic [RES2_W-1:0] res_second;
	} slot_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_PROBE = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_WB    = 6'b100000
	} state_t;

endpackage : pfqs_pkg
`default_nettype wire

FILE: src/pfqs_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfqs_hash
// Home slot of a flow key: key modulo the table depth. A power-of-two depth
// takes the low bits; any other depth registers the exact quotient, formed by
// reciprocal multiplication, and then the remainder.
// ----------------------------------------------------------------------------
module pfqs_hash #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire [pfqs_pkg::KEY_W-1:0] key,
	output logic                    done,
	output logic [IDX_W-1:0]        home
);
	import pfqs_pkg::*;

	if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
		logic             done_q;
		logic [IDX_W-1:0] home_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				home_q <= key[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign home = home_q;
	end else begin : g_recip
		// With 2^(IDX_W-1) < DEPTH < 2^IDX_W and a key below 2^KEY_W, the key
		// times RECIP shifted right by SHIFT is exactly key / DEPTH.
		localparam int SHIFT = KEY_W + IDX_W;
		localparam logic [KEY_W:0] RECIP =
			(KEY_W+1)'(((64'd1 << SHIFT) / 64'(DEPTH)) + 64'd1);
		localparam logic [KEY_W-1:0] DEPTH_K = KEY_W'(DEPTH);

		logic             valid_s1;
		logic [KEY_W-1:0] key_s1;
		logic [KEY_W-1:0] quot_s1;
		logic             done_q;
		logic [IDX_W-1:0] home_q;
		logic [2*KEY_W:0] prod;
		logic [KEY_W-1:0] back;
		logic [KEY_W-1:0] diff;

		assign prod = (2*KEY_W+1)'(key) * (2*KEY_W+1)'(RECIP);
		assign back = quot_s1 * DEPTH_K;
		assign diff = key_s1 - back;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s1 <= 1'b0;
				done_q   <= 1'b0;
			end else begin
				valid_s1 <= start;
				done_q   <= valid_s1;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				key_s1  <= key;
				quot_s1 <= KEY_W'(prod >> SHIFT);
			end
			if (valid_s1) begin
				home_q <= diff[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign home = home_q;
	end

endmodule : pfqs_hash
`default_nettype wire

FILE: src/pfqs_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfqs_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfqs_mem #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [IDX_W-1:0]      waddr,
	input  pfqs_pkg::slot_t      wdata,
	input  wire                  re,
	input  wire [IDX_W-1:0]      raddr,
	output pfqs_pkg::slot_t      rdata
);
	import pfqs_pkg::*;

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : pfqs_mem
`default_nettype wire

FILE: src/per_flow_qos_statistics_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_flow_qos_statistics_table
// Hashed table of per-(UE, QoS flow) packet and byte counters with linear
// probing; reports new flows and periodic counts of two watched flow ids.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tdata: ue_id, qfi, packet_length
//  m_axis    out        tvalid / tready        tdata: ue, qfi, packets, bytes
//                                              tuser: new_flow, stored
//  cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
//  After reset a clearing pass writes every slot invalid; s_axis_tready
//  stays low meanwhile, configuration writes are taken.
//  An item passes the hash, probe, add and write-back states, staying in probe
//  for each further slot; the slot memory reads one slot a cycle.
//  A full table is walked once in full. A depth that is not a power of two
//  adds a registered remainder step to the home slot computation.
//  A result waits in the output register; a stalled output holds back the
//  write-back of the next item that reports, and with it the input.
// ----------------------------------------------------------------------------
module per_flow_qos_statistics_table #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// [15:0] ue_id, [21:16] qfi, [37:22] packet_length, [39:38] zero
	input  wire [pfqs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// [15:0] report_ue, [21:16] report_qfi, [85:22] report_packets,
	// [149:86] report_bytes, [151:150] zero
	output logic [pfqs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// [0] report_new_flow, [1] report_stored
	output logic [pfqs_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	input  wire                                cfg_we,
	input  wire [pfqs_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire [pfqs_pkg::REG_DATA_W-1:0]     cfg_data
);
	import pfqs_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int NUM_W = $clog2(TABLE_ENTRIES + 1);

	state_t state_q;

	logic [QFI_W-1:0] watch_first_q;
	logic [QFI_W-1:0] watch_second_q;

	logic [UE_W-1:0]  ue_q;
	logic [QFI_W-1:0] qfi_q;
	logic [LEN_W-1:0] len_q;

	logic [IDX_W-1:0] clr_idx_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] pos_next;
	logic [NUM_W-1:0] probes_q;
	logic [NUM_W-1:0] flows_in_use_q;

	logic found_q;
	logic store_q;

	slot_t upd_q;
	logic  report_q;
	logic  write_q;

	logic             out_valid_q;
	logic [UE_W-1:0]  out_ue_q;
	logic [QFI_W-1:0] out_qfi_q;
	logic [CNT_W-1:0] out_packets_q;
	logic [CNT_W-1:0] out_bytes_q;
	logic             out_new_q;
	logic             out_stored_q;

	logic             in_accept;
	logic [UE_W-1:0]  in_ue;
	logic [QFI_W-1:0] in_qfi;
	logic [LEN_W-1:0] in_len;
	logic             hash_done;
	logic [IDX_W-1:0] hash_home;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	slot_t            mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	slot_t            mem_rdata;

	logic             out_free;
	logic             wb_go;
	logic             out_load;
	logic             key_match;

	slot_t            add_slot;
	logic             add_report;
	logic             pk_wrap;
	logic [CNT_W-1:0] pk_inc;

	assign in_ue  = s_axis_tdata[UE_W-1:0];
	assign in_qfi = s_axis_tdata[UE_W+QFI_W-1:UE_W];
	assign in_len = s_axis_tdata[KEY_W+LEN_W-1:KEY_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign out_free = !out_valid_q || m_axis_tready;
	assign wb_go    = (state_q == ST_WB) && (!report_q || out_free);
	assign out_load = wb_go && report_q;

	assign key_match = (mem_rdata.key == {ue_q, qfi_q});
	assign pos_next  = (pos_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : pos_q + 1'b1;

	pfqs_hash #(
		.DEPTH (TABLE_ENTRIES)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.key    ({in_ue, in_qfi}),
		.done   (hash_done),
		.home   (hash_home)
	);

	pfqs_mem #(
		.DEPTH (TABLE_ENTRIES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Read port: home slot once the hash is ready, then one slot per probe.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = hash_home;
		if (state_q == ST_HASH && hash_done) begin
			mem_re = 1'b1;
		end else if (state_q == ST_PROBE && mem_rdata.valid && !key_match &&
				probes_q != NUM_W'(TABLE_ENTRIES - 1)) begin
			mem_re    = 1'b1;
			mem_raddr = pos_next;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = upd_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else if (wb_go && write_q) begin
			mem_we = 1'b1;
		end
	end

	// Counter update of a found flow, or the fresh counters of a new one.
	// A packet count that wraps to zero restarts both residues at zero.
	always_comb begin
		pk_inc  = mem_rdata.packets + 1'b1;
		pk_wrap = (mem_rdata.packets == '1);
		add_slot.valid = 1'b1;
		add_slot.key   = {ue_q, qfi_q};
		if (found_q) begin
			add_slot.packets = pk_inc;
			add_slot.bytes   = mem_rdata.bytes + CNT_W'(len_q);
			if (pk_wrap || mem_rdata.res_first == RES1_W'(FIRST_PERIOD - 1)) begin
				add_slot.res_first = '0;
			end else begin
				add_slot.res_first = mem_rdata.res_first + 1'b1;
			end
			if (pk_wrap || mem_rdata.res_second == RES2_W'(SECOND_PERIOD - 1)) begin
				add_slot.res_second = '0;
			end else begin
				add_slot.res_second = mem_rdata.res_second + 1'b1;
			end
			add_report = (qfi_q == watch_first_q && add_slot.res_first == '0) ||
				(qfi_q == watch_second_q && add_slot.res_second == '0);
		end else begin
			add_slot.packets    = CNT_W'(1);
			add_slot.bytes      = CNT_W'(len_q);
			add_slot.res_first  = RES1_W'(1);
			add_slot.res_second = RES2_W'(1);
			add_report          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_idx_q      <= '0;
			probes_q       <= '0;
			flows_in_use_q <= '0;
			found_q        <= 1'b0;
			store_q        <= 1'b0;
			report_q       <= 1'b0;
			write_q        <= 1'b0;
			watch_first_q  <= WATCH_FIRST_RST;
			watch_second_q <= WATCH_SECOND_RST;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WATCH_FIRST: begin
						watch_first_q <= cfg_data;
					end
					REG_WATCH_SECOND: begin
						watch_second_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						probes_q <= '0;
						state_q  <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (!mem_rdata.valid) begin
						found_q <= 1'b0;
						store_q <= (flows_in_use_q < NUM_W'(TABLE_ENTRIES));
						state_q <= ST_ADD;
					end else if (key_match) begin
						found_q <= 1'b1;
						store_q <= 1'b1;
						state_q <= ST_ADD;
					end else if (probes_q == NUM_W'(TABLE_ENTRIES - 1)) begin
						found_q <= 1'b0;
						store_q <= 1'b0;
						state_q <= ST_ADD;
					end else begin
						probes_q <= probes_q + 1'b1;
					end
				end
				ST_ADD: begin
					report_q <= add_report;
					write_q  <= store_q;
					state_q  <= ST_WB;
				end
				ST_WB: begin
					if (wb_go) begin
						if (write_q && !found_q) begin
							flows_in_use_q <= flows_in_use_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ue_q  <= in_ue;
			qfi_q <= in_qfi;
			len_q <= in_len;
		end
		if (state_q == ST_HASH && hash_done) begin
			pos_q <= hash_home;
		end else if (mem_re) begin
			pos_q <= pos_next;
		end
		if (state_q == ST_ADD) begin
			upd_q <= add_slot;
		end
		if (out_load) begin
			out_ue_q      <= upd_q.key[KEY_W-1:QFI_W];
			out_qfi_q     <= upd_q.key[QFI_W-1:0];
			out_packets_q <= upd_q.packets;
			out_bytes_q   <= upd_q.bytes;
			out_new_q     <= !found_q;
			out_stored_q  <= write_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(OUT_DATA_W - KEY_W - 2*CNT_W)'(0),
		out_bytes_q, out_packets_q, out_qfi_q, out_ue_q
	};
	assign m_axis_tuser  = {out_stored_q, out_new_q};

	// Checks.
	a_accept_to_hash: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_HASH)
		else $error("accepted item did not start hashing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result loaded over a pending result");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> probes_q < NUM_W'(TABLE_ENTRIES))
		else $error("probe walked past the table depth");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flows_in_use_q <= NUM_W'(TABLE_ENTRIES))
		else $error("flow count exceeds table depth");

endmodule : per_flow_qos_statistics_table
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-flow QoS statistics table. Packet records
// go in on the input stream and a predictor keeps its own copy of the flow
// table to work out which reports must come out. Every report is compared
// field by field with the oldest one expected. The stimulus covers the hashed
// probe paths, both watch registers, a long run on one flow, and a table
// filled to capacity.
// ----------------------------------------------------------------------------
module tb_top;
	import pfqs_pkg::*;

	localparam int SLOTS            = 1024;
	localparam int WARM_FLOWS       = 16;
	localparam int HOT_TARGET       = 1010;
	localparam int SETTLE_CYCLES    = 1200;
	localparam int LONG_HOLD_AFTER  = 150;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT      = 1000000;

	typedef struct {
		bit [UE_W-1:0]  ue;
		bit [QFI_W-1:0] qfi;
		bit [CNT_W-1:0] packets;
		bit [CNT_W-1:0] bytes;
		bit             new_flow;
		bit             stored;
	} flow_report_t;

	// Flow table predictor and the queue of reports it still expects.
	class flow_counter_board;
		bit               occupied[SLOTS];
		bit [KEY_W-1:0]   flow_key[SLOTS];
		bit [CNT_W-1:0]   pkt_count[SLOTS];
		bit [CNT_W-1:0]   flow_bytes[SLOTS];
		int unsigned      stored_flows;
		bit [QFI_W-1:0]   watch_first;
		bit [QFI_W-1:0]   watch_second;
		flow_report_t     expected_reports[$];
		int unsigned      mismatches;

		function new();
			foreach (occupied[i]) occupied[i] = 1'b0;
			stored_flows = 0;
			watch_first  = WATCH_FIRST_RST;
			watch_second = WATCH_SECOND_RST;
			mismatches   = 0;
		endfunction

		function void set_watch(bit [REG_IDX_W-1:0] idx, bit [REG_DATA_W-1:0] value);
			if (idx == REG_WATCH_FIRST)
				watch_first = value;
			else if (idx == REG_WATCH_SECOND)
				watch_second = value;
		endfunction

		// Linear probe from the home slot: stops on the key or on a free slot.
		function void probe(bit [KEY_W-1:0] key, output int unsigned pos,
				output bit hit, output bit vacant);
			hit = 1'b0;
			vacant = 1'b0;
			pos = key % SLOTS;
			for (int n = 0; n < SLOTS; n++) begin
				if (!occupied[pos]) begin
					vacant = 1'b1;
					return;
				end
				if (flow_key[pos] == key) begin
					hit = 1'b1;
					return;
				end
				pos = (pos + 1) % SLOTS;
			end
		endfunction

		function bit [CNT_W-1:0] packets_of(bit [KEY_W-1:0] key);
			int unsigned pos;
			bit hit, vacant;
			probe(key, pos, hit, vacant);
			return hit ? pkt_count[pos] : '0;
		endfunction

		function int unsigned free_slot_from(int unsigned start);
			int unsigned pos;
			pos = start;
			for (int n = 0; n < SLOTS; n++) begin
				if (!occupied[pos])
					return pos;
				pos = (pos + 1) % SLOTS;
			end
			return start;
		endfunction

		function void account_packet(bit [KEY_W-1:0] key, bit [LEN_W-1:0] len);
			int unsigned pos;
			bit hit, vacant;
			flow_report_t r;
			probe(key, pos, hit, vacant);
			r.ue  = key[KEY_W-1:QFI_W];
			r.qfi = key[QFI_W-1:0];
			if (!hit) begin
				r.packets  = 1;
				r.bytes    = len;
				r.new_flow = 1'b1;
				r.stored   = 1'b0;
				if (vacant && stored_flows < SLOTS) begin
					occupied[pos]   = 1'b1;
					flow_key[pos]   = key;
					pkt_count[pos]  = 1;
					flow_bytes[pos] = len;
					stored_flows++;
					r.stored = 1'b1;
				end
				expected_reports.push_back(r);
				return;
			end
			pkt_count[pos]  += 1;
			flow_bytes[pos] += len;
			// When both watches name this flow, a count that hits both periods
			// still yields a single report.
			if ((r.qfi == watch_first && pkt_count[pos] % FIRST_PERIOD == 0) ||
					(r.qfi == watch_second && pkt_count[pos] % SECOND_PERIOD == 0)) begin
				r.packets  = pkt_count[pos];
				r.bytes    = flow_bytes[pos];
				r.new_flow = 1'b0;
				r.stored   = 1'b1;
				expected_reports.push_back(r);
			end
		endfunction

		function void compare_field(string field, bit [CNT_W-1:0] want, bit [CNT_W-1:0] got);
			if (want != got) begin
				$error("%s: expected %0h, actual %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(bit [OUT_DATA_W-1:0] data, bit [OUT_USER_W-1:0] user);
			flow_report_t want;
			if (expected_reports.size() == 0) begin
				$error("unexpected report: ue %0h qfi %0d", data[15:0], data[21:16]);
				mismatches++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("report_ue", want.ue, data[15:0]);
			compare_field("report_qfi", want.qfi, data[21:16]);
			compare_field("report_packets", want.packets, data[85:22]);
			compare_field("report_bytes", want.bytes, data[149:86]);
			compare_field("report_new_flow", want.new_flow, user[0]);
			compare_field("report_stored", want.stored, user[1]);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [REG_DATA_W-1:0] cfg_data = '0;

	flow_counter_board board = new();
	int unsigned       burst_left = 0;
	bit [KEY_W-1:0]    hot_key;
	bit [KEY_W-1:0]    warm_keys[WARM_FLOWS];

	per_flow_qos_statistics_table #(
		.TABLE_ENTRIES(SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_report(m_axis_tdata, m_axis_tuser);
	end

	// Report sink: changes its stall style at random intervals, and once holds
	// off long enough for the block to back up into its input.
	initial begin : report_sink
		int unsigned style, style_left, taken;
		bit          held;
		style = 0;
		style_left = 0;
		taken = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				taken++;
			if (!held && taken >= LONG_HOLD_AFTER) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			if (style_left == 0) begin
				style = $urandom_range(3);
				style_left = $urandom_range(100, 20);
			end
			style_left--;
			case (style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(99) < 50);
				2: m_axis_tready <= ($urandom_range(99) < 85);
				default: m_axis_tready <= (style_left % 16 >= 6);
			endcase
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic bit [LEN_W-1:0] pick_length();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return LEN_W'($urandom);
		endcase
	endfunction

	// Offers one packet record; bursts of random length are separated by
	// random gaps. The predictor sees the transaction as soon as it is taken.
	task automatic offer(input bit [KEY_W-1:0] key, input bit [LEN_W-1:0] len);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(99) < 35) ? 0 : $urandom_range(8, 1);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(16, 1);
		end
		burst_left--;
		s_axis_tdata  <= {2'b00, len, key[QFI_W-1:0], key[KEY_W-1:QFI_W]};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		board.account_packet(key, len);
	endtask

	// Stops offering until every expected report is out, then keeps waiting
	// in case a silent packet is still in flight.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (board.expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_watch(input bit [REG_IDX_W-1:0] idx,
			input bit [REG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_watch(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic mixed_traffic(input int unsigned count);
		int unsigned    roll;
		bit [KEY_W-1:0] key;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 70)
				key = hot_key;
			else if (roll < 85)
				key = warm_keys[$urandom_range(WARM_FLOWS - 1)];
			else
				key = KEY_W'($urandom);
			offer(key, pick_length());
		end
	endtask

	// New flows placed straight into free home slots until the table is full,
	// interleaved with the hot flow until it is past its thousandth packet.
	task automatic fill_table();
		int unsigned    slot;
		bit [KEY_W-1:0] key;
		bit             hot_done;
		hot_done = board.packets_of(hot_key) >= HOT_TARGET;
		while (board.stored_flows < SLOTS || !hot_done) begin
			if (board.stored_flows < SLOTS && (hot_done || $urandom_range(1) == 1)) begin
				slot = board.free_slot_from($urandom_range(SLOTS - 1));
				key = KEY_W'($urandom_range((1 << KEY_W) / SLOTS - 1) * SLOTS + slot);
			end else begin
				key = hot_key;
			end
			offer(key, pick_length());
			hot_done = board.packets_of(hot_key) >= HOT_TARGET;
		end
	endtask

	initial begin : stimulus
		bit [KEY_W-1:0] lost_key;
		hot_key = {16'($urandom), WATCH_FIRST_RST};
		foreach (warm_keys[i]) begin
			warm_keys[i] = KEY_W'($urandom);
			if (i % 4 == 0)
				warm_keys[i][QFI_W-1:0] = '0;
			else if (i % 4 == 1)
				warm_keys[i][QFI_W-1:0] = '1;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, then keys sharing a home slot so that the probe
		// steps forward and wraps from the last slot to the first.
		offer({16'h0000, 6'd0}, 16'h0000);
		offer({16'h0000, 6'd0}, 16'hFFFF);
		offer({16'hFFFF, 6'd63}, 16'hFFFF);
		offer({16'h0010, 6'd0}, 16'd100);
		offer({16'h002F, 6'd63}, 16'h0001);
		offer({16'h002F, 6'd63}, 16'h8000);
		offer({16'h0010, 6'd0}, 16'h7FFF);
		offer({16'hFFFF, 6'd63}, 16'h0000);
		offer({16'h0001, WATCH_FIRST_RST}, 16'h0001);
		offer({16'h0002, WATCH_SECOND_RST}, 16'h00FF);
		offer({16'h8000, 6'd32}, 16'h8000);
		offer({16'h7FFF, 6'd31}, 16'h7FFF);
		offer({16'h0001, WATCH_FIRST_RST}, 16'hFFFF);
		drain();

		mixed_traffic(200);
		drain();
		program_watch(REG_WATCH_FIRST, '1);
		program_watch(REG_WATCH_SECOND, '0);
		mixed_traffic(120);
		drain();

		// Both watches on the hot flow: its thousandth packet must give one
		// report, not two.
		program_watch(REG_WATCH_FIRST, WATCH_FIRST_RST);
		program_watch(REG_WATCH_SECOND, WATCH_FIRST_RST);
		fill_table();

		// Table full: new flows walk the whole table and come back unstored,
		// and a repeat of an unstored flow is new again.
		lost_key = KEY_W'($urandom);
		offer(lost_key, pick_length());
		offer(lost_key, pick_length());
		offer(hot_key, pick_length());
		offer(warm_keys[0], pick_length());
		offer(22'($urandom), 16'hFFFF);
		offer({16'h0000, 6'd0}, 16'h0000);
		offer(22'($urandom), 16'h0000);
		drain();

		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: per_flow_qos_statistics_table.f
src/pfqs_pkg.sv
src/pfqs_hash.sv
src/pfqs_mem.sv
src/per_flow_qos_statistics_table.sv
dv/tb_top.sv
